/* sv/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Holds table geometry, field widths, status codes and the small helpers
// that the controller, datapath and top level all use.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

	localparam int MAX_RANGES  = 16;
	localparam int OFFSET_BITS = 24;
	localparam int VAL_W       = OFFSET_BITS + 1;
	localparam int SUM_W       = VAL_W + 1;
	localparam int IDX_W       = $clog2(MAX_RANGES);
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);

	localparam logic [VAL_W-1:0] CAP_RESET = VAL_W'(1) << OFFSET_BITS;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // latch the request and rewind the scan
		logic step;    // move the scan on by one entry
		logic update;  // apply the change and register the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic more;    // the scan must look at the next entry
	} sts_t;

	// Saturating narrow of a sum of two table values.
	function automatic logic [VAL_W-1:0] sat_val(input logic [SUM_W-1:0] s);
		logic [VAL_W-1:0] r;
		r = s[VAL_W] ? {VAL_W{1'b1}} : s[VAL_W-1:0];
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] ext(input logic [VAL_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = {1'b0, v};
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/ffra_if.sv */
// ----------------------------------------------------------------------------
// ffra interfaces: request, response and capacity channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if;
	logic                             valid;
	logic                             ready;
	logic                             func;
	logic [ffra_pkg::OFFSET_BITS-1:0] range_offset;
	logic [ffra_pkg::VAL_W-1:0]       range_size;

	modport source (output valid, func, range_offset, range_size, input ready);
	modport sink   (input valid, func, range_offset, range_size, output ready);
endinterface

interface ffra_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [ffra_pkg::VAL_W-1:0] granted_offset;

	modport source (output valid, status, granted_offset, input ready);
	modport sink   (input valid, status, granted_offset, output ready);
endinterface

interface ffra_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ffra_pkg::VAL_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

/* sv/ffra_datapath.sv */
// ----------------------------------------------------------------------------
// ffra_datapath: free range table, scan pointer and update logic
// Keeps the sorted table of free ranges and performs one scan step or one
// table update per cycle under control of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ffra_pkg::cmd_t                   cmd,
	output      ffra_pkg::sts_t                   sts,
	input  wire logic                             req_func,
	input  wire logic [ffra_pkg::OFFSET_BITS-1:0] req_offset,
	input  wire logic [ffra_pkg::VAL_W-1:0]       req_size,
	input  wire logic                             cfg_wr,
	input  wire logic [ffra_pkg::VAL_W-1:0]       cfg_capacity,
	output      ffra_pkg::status_t                res_status,
	output      logic [ffra_pkg::VAL_W-1:0]       res_offset
);

	logic [ffra_pkg::VAL_W-1:0] start_q [ffra_pkg::MAX_RANGES];
	logic [ffra_pkg::VAL_W-1:0] len_q   [ffra_pkg::MAX_RANGES];
	logic [ffra_pkg::VAL_W-1:0] start_d [ffra_pkg::MAX_RANGES];
	logic [ffra_pkg::VAL_W-1:0] len_d   [ffra_pkg::MAX_RANGES];
	logic [ffra_pkg::CNT_W-1:0] count_q, count_d;
	logic [ffra_pkg::CNT_W-1:0] idx_q;
	logic [ffra_pkg::SUM_W-1:0] prev_end_q;
	logic [ffra_pkg::VAL_W-1:0] prev_len_q;
	logic                             func_q;
	logic [ffra_pkg::OFFSET_BITS-1:0] off_q;
	logic [ffra_pkg::VAL_W-1:0]       size_q;
	ffra_pkg::status_t                res_status_q;
	logic [ffra_pkg::VAL_W-1:0]       res_offset_q;

	logic [ffra_pkg::IDX_W-1:0] pos;
	logic [ffra_pkg::VAL_W-1:0] cur_start, cur_len;
	logic [ffra_pkg::SUM_W-1:0] off_ext, end_sum;
	logic                       in_range, fits, more;
	logic                       mp, mn, zero_size;
	logic                       wa_en, rm_en, ins_en;
	logic [ffra_pkg::IDX_W-1:0] wa_idx;
	logic [ffra_pkg::VAL_W-1:0] wa_start, wa_len;
	logic [ffra_pkg::VAL_W-1:0] rem_len, merged_len;
	ffra_pkg::status_t          upd_status;
	logic [ffra_pkg::VAL_W-1:0] upd_offset;

	assign pos       = idx_q[ffra_pkg::IDX_W-1:0];
	assign cur_start = start_q[pos];
	assign cur_len   = len_q[pos];
	assign in_range  = idx_q < count_q;
	assign fits      = cur_len >= size_q;
	assign zero_size = size_q == '0;
	assign off_ext   = {{(ffra_pkg::SUM_W - ffra_pkg::OFFSET_BITS){1'b0}}, off_q};
	assign end_sum   = off_ext + ffra_pkg::ext(size_q);
	assign rem_len   = cur_len - size_q;
	assign mp        = (idx_q != '0) && (prev_end_q == off_ext);
	assign mn        = in_range && (end_sum == ffra_pkg::ext(cur_start));
	assign merged_len = ffra_pkg::sat_val(
		ffra_pkg::ext(ffra_pkg::sat_val(ffra_pkg::ext(prev_len_q) + ffra_pkg::ext(size_q)))
		+ ffra_pkg::ext(cur_len));

	always_comb begin
		if (func_q == ffra_pkg::FN_ALLOC) begin
			more = in_range && !fits;
		end else begin
			more = !zero_size && in_range && (ffra_pkg::ext(cur_start) < off_ext);
		end
	end
	assign sts.more = more;

	// Decide the table change and the result of the current request.
	always_comb begin
		wa_en      = 1'b0;
		wa_idx     = pos;
		wa_start   = cur_start;
		wa_len     = cur_len;
		rm_en      = 1'b0;
		ins_en     = 1'b0;
		upd_status = ffra_pkg::ST_OK;
		upd_offset = '0;
		if (func_q == ffra_pkg::FN_ALLOC) begin
			if (!in_range) begin
				upd_status = ffra_pkg::ST_NOFIT;
			end else begin
				upd_offset = cur_start;
				if (rem_len == '0) begin
					rm_en = 1'b1;
				end else begin
					wa_en    = 1'b1;
					wa_len   = rem_len;
					wa_start = ffra_pkg::sat_val(ffra_pkg::ext(cur_start)
						+ ffra_pkg::ext(size_q));
				end
			end
		end else if (!zero_size) begin
			if (mp && mn) begin
				wa_en    = 1'b1;
				wa_idx   = pos - 1'b1;
				wa_start = start_q[pos - 1'b1];
				wa_len   = merged_len;
				rm_en    = 1'b1;
			end else if (mp) begin
				wa_en    = 1'b1;
				wa_idx   = pos - 1'b1;
				wa_start = start_q[pos - 1'b1];
				wa_len   = ffra_pkg::sat_val(ffra_pkg::ext(prev_len_q)
					+ ffra_pkg::ext(size_q));
			end else if (mn) begin
				wa_en    = 1'b1;
				wa_start = off_ext[ffra_pkg::VAL_W-1:0];
				wa_len   = ffra_pkg::sat_val(ffra_pkg::ext(cur_len)
					+ ffra_pkg::ext(size_q));
			end else if (count_q == ffra_pkg::CNT_W'(ffra_pkg::MAX_RANGES)) begin
				upd_status = ffra_pkg::ST_FULL;
			end else begin
				wa_en    = 1'b1;
				wa_start = off_ext[ffra_pkg::VAL_W-1:0];
				wa_len   = size_q;
				ins_en   = 1'b1;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cfg_wr) begin
			count_d = (cfg_capacity != '0) ? ffra_pkg::CNT_W'(1) : '0;
		end else if (cmd.update && rm_en) begin
			count_d = count_q - 1'b1;
		end else if (cmd.update && ins_en) begin
			count_d = count_q + 1'b1;
		end
	end

	// Each entry either keeps its value, takes the write, or shifts by one place.
	for (genvar j = 0; j < ffra_pkg::MAX_RANGES; j++) begin : g_ent
		logic [ffra_pkg::VAL_W-1:0] up_start, up_len, dn_start, dn_len;

		if (j < ffra_pkg::MAX_RANGES - 1) begin : g_up
			assign up_start = start_q[j+1];
			assign up_len   = len_q[j+1];
		end else begin : g_last
			assign up_start = start_q[j];
			assign up_len   = len_q[j];
		end
		if (j > 0) begin : g_dn
			assign dn_start = start_q[j-1];
			assign dn_len   = len_q[j-1];
		end else begin : g_first
			assign dn_start = start_q[j];
			assign dn_len   = len_q[j];
		end

		always_comb begin
			start_d[j] = start_q[j];
			len_d[j]   = len_q[j];
			if (cfg_wr) begin
				if (j == 0) begin
					start_d[j] = '0;
					len_d[j]   = cfg_capacity;
				end
			end else if (cmd.update) begin
				if (wa_en && (ffra_pkg::IDX_W'(j) == wa_idx)) begin
					start_d[j] = wa_start;
					len_d[j]   = wa_len;
				end else if (rm_en && (ffra_pkg::IDX_W'(j) >= pos)) begin
					start_d[j] = up_start;
					len_d[j]   = up_len;
				end else if (ins_en && (ffra_pkg::IDX_W'(j) > pos)) begin
					start_d[j] = dn_start;
					len_d[j]   = dn_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ffra_pkg::MAX_RANGES; j++) begin
				start_q[j] <= '0;
				len_q[j]   <= (j == 0) ? ffra_pkg::CAP_RESET : '0;
			end
			count_q <= ffra_pkg::CNT_W'(1);
			idx_q   <= '0;
		end else begin
			for (int j = 0; j < ffra_pkg::MAX_RANGES; j++) begin
				start_q[j] <= start_d[j];
				len_q[j]   <= len_d[j];
			end
			count_q <= count_d;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= req_func;
			off_q  <= req_offset;
			size_q <= req_size;
		end
		if (cmd.step) begin
			prev_end_q <= ffra_pkg::ext(cur_start) + ffra_pkg::ext(cur_len);
			prev_len_q <= cur_len;
		end
		if (cmd.update) begin
			res_status_q <= upd_status;
			res_offset_q <= upd_offset;
		end
	end

	assign res_status = res_status_q;
	assign res_offset = res_offset_q;

endmodule

`default_nettype wire

/* sv/ffra_ctrl.sv */
// ----------------------------------------------------------------------------
// ffra_ctrl: request sequencer of the first-fit range allocator
// Takes a request, steps the datapath scan, triggers the update and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire logic           out_free,
	output      logic           out_load,
	output      ffra_pkg::cmd_t cmd,
	input  wire ffra_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		out_load   = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				// The last scan cycle also applies the change to the table.
				if (sts.more) begin
					cmd.step = 1'b1;
				end else begin
					cmd.update = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* sv/first_fit_range_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top: first-fit range allocator with coalescing
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------
//   req     | in  | func, range_offset, range_size
//   rsp     | out | status, granted_offset
//   cfg     | in  | capacity (reinitialises the free table)
//
// A request is taken in the idle state; the scan then passes over k table
// entries (0 to MAX_RANGES), the update registers the result and the output
// register is loaded. The single table compare port visits one entry per
// cycle. The next request can transfer in the cycle after the result is loaded.
// The result sits in an output register, so the next request is taken while
// it waits. Reset leaves one free range of 2^24 units; no clearing pass is
// needed. A stalled rsp holds the sequencer in its final state until the
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_range_allocator_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffra_req_if.sink    req,
	ffra_rsp_if.source  rsp,
	ffra_cfg_if.sink    cfg
);

	ffra_pkg::cmd_t             cmd;
	ffra_pkg::sts_t             sts;
	ffra_pkg::status_t          res_status;
	logic [ffra_pkg::VAL_W-1:0] res_offset;
	logic                       out_free, out_load;
	logic                       rsp_valid_q;
	logic [1:0]                 rsp_status_q;
	logic [ffra_pkg::VAL_W-1:0] rsp_offset_q;

	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.out_free  (out_free),
		.out_load  (out_load),
		.cmd       (cmd),
		.sts       (sts)
	);

	ffra_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_func     (req.func),
		.req_offset   (req.range_offset),
		.req_size     (req.range_size),
		.cfg_wr       (cfg.valid),
		.cfg_capacity (cfg.capacity),
		.res_status   (res_status),
		.res_offset   (res_offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= res_status;
			rsp_offset_q <= res_offset;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.granted_offset = rsp_offset_q;

endmodule

`default_nettype wire

/* sv/ffra_checker.sv */
// ----------------------------------------------------------------------------
// ffra_checker: port-level checks of the range allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [1:0]                 rsp_status,
	input wire logic [ffra_pkg::VAL_W-1:0] rsp_offset
);

	// A stalled result holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset))
		else $error("response changed while stalled");

	// Only a successful allocate carries an offset.
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ffra_pkg::ST_OK |-> rsp_offset == '0)
		else $error("offset on a failed request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != ffra_pkg::ST_UNUSED)
		else $error("undefined status code");

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_offset (rsp.granted_offset)
);

`default_nettype wire
